@@ rtl/epid_pkg.sv @@
// Package with shared types and constants for the ECG peak interval detector.
`timescale 1ns / 1ps

package epid_pkg;

    // Field widths fixed by the item format.
    localparam int SAMPLE_BITS = 16;
    localparam int TIME_BITS   = 32;
    localparam int COUNT_BITS  = 20;
    localparam int SUM_BITS    = 48;
    localparam int MEAN_BITS   = 32;

    // Divider sizing: one quotient bit per step over the whole sum.
    localparam int DIV_STEPS     = SUM_BITS;
    localparam int DIV_STEP_BITS = $clog2(DIV_STEPS);
    localparam int REM_BITS      = COUNT_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [MEAN_BITS-1:0]  MEAN_MAX  = {MEAN_BITS{1'b1}};

    // One input transaction.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic [TIME_BITS-1:0]          sample_time;
        logic                          record_end;
    } epid_in_t;

    // One result transaction.
    typedef struct packed {
        logic                  peak_found;
        logic [TIME_BITS-1:0]  peak_time;
        logic [COUNT_BITS-1:0] peak_total;
        logic [MEAN_BITS-1:0]  mean_interval;
        logic                  record_done;
    } epid_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // process the accepted input transaction
        logic publish;     // mark the result register valid now
        logic div_step;    // run one divider step
        logic div_finish;  // write the mean and mark the result valid
    } epid_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;    // result register holds a transaction not taken this cycle
        logic need_div;    // current input ends a record with two or more peaks
        logic div_last;    // divider is on its final step
    } epid_stat_t;

endpackage

@@ rtl/epid_ctrl.sv @@
// Controller state machine for the ECG peak interval detector.
`timescale 1ns / 1ps

module epid_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  epid_pkg::epid_stat_t stat,
    output epid_pkg::epid_cmd_t  cmd
);

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // Inputs are taken only while running and when the result register frees up.
    assign in_stall = (state_reg != ST_RUN) || stat.out_busy;
    assign accept   = in_valid && !in_stall;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        cmd.take       = 1'b0;
        cmd.publish    = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.div_finish = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    cmd.take = 1'b1;
                    if (stat.need_div)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cmd.publish = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.div_finish = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/epid_datapath.sv @@
// Datapath: sample window, peak test, count and sum, divider and result register.
`timescale 1ns / 1ps

module epid_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic signed [epid_pkg::SAMPLE_BITS-1:0] cfg_wr_data,
    input  epid_pkg::epid_in_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output epid_pkg::epid_out_t                   out_data,
    input  epid_pkg::epid_cmd_t                   cmd,
    output epid_pkg::epid_stat_t                  stat
);

    localparam int SB = epid_pkg::SAMPLE_BITS;
    localparam int TB = epid_pkg::TIME_BITS;
    localparam int CB = epid_pkg::COUNT_BITS;
    localparam int WB = epid_pkg::SUM_BITS;
    localparam int MB = epid_pkg::MEAN_BITS;
    localparam int RB = epid_pkg::REM_BITS;
    localparam int KB = epid_pkg::DIV_STEP_BITS;

    // Configuration and record state.
    logic signed [SB-1:0] thr_reg;
    logic signed [SB-1:0] older_reg;
    logic signed [SB-1:0] middle_reg;
    logic [TB-1:0]        mid_time_reg;
    logic [1:0]           seen_reg;
    logic [CB-1:0]        count_reg;
    logic [TB-1:0]        last_time_reg;
    logic [WB-1:0]        sum_reg;

    // Divider registers.
    logic [WB-1:0] quot_reg;
    logic [RB-1:0] rem_reg;
    logic [CB-1:0] dvsr_reg;
    logic [KB-1:0] step_reg;

    // Result register.
    logic                out_valid_reg;
    epid_pkg::epid_out_t out_reg;

    // Peak test and accumulator updates.
    logic          is_peak;
    logic [TB-1:0] gap;
    logic [WB:0]   sum_add;
    logic [WB-1:0] sum_next;
    logic [CB-1:0] count_next;
    logic [CB-1:0] count_inc;

    // Divider step.
    logic [RB-1:0] rem_shift;
    logic          q_bit;
    logic [RB-1:0] rem_next;
    logic [WB-1:0] quot_next;
    logic [MB-1:0] mean_sat;

    // Judge the middle sample against its neighbors and the threshold.
    always_comb
    begin
        is_peak = (seen_reg == 2'd2) && (middle_reg > thr_reg) &&
                  (middle_reg > older_reg) && (middle_reg > in_data.sample_value);
        gap       = mid_time_reg - last_time_reg;
        sum_add   = {1'b0, sum_reg} + {{(WB + 1 - TB){1'b0}}, gap};
        count_inc = (count_reg == epid_pkg::COUNT_MAX) ? count_reg : count_reg + CB'(1);
        sum_next   = sum_reg;
        count_next = count_reg;
        if (is_peak)
        begin
            count_next = count_inc;
            if (count_reg != '0)
            begin
                sum_next = sum_add[WB] ? epid_pkg::SUM_MAX : sum_add[WB-1:0];
            end
        end
    end

    // One restoring division step per cycle, most significant bit first.
    always_comb
    begin
        rem_shift = {rem_reg[RB-2:0], quot_reg[WB-1]};
        q_bit     = rem_shift >= {1'b0, dvsr_reg};
        rem_next  = q_bit ? (rem_shift - {1'b0, dvsr_reg}) : rem_shift;
        quot_next = {quot_reg[WB-2:0], q_bit};
        mean_sat  = (quot_next[WB-1:MB] != '0) ? epid_pkg::MEAN_MAX : quot_next[MB-1:0];
    end

    // Status back to the controller.
    assign stat.out_busy = out_valid_reg && out_stall;
    assign stat.need_div = in_data.record_end && (count_next >= CB'(2));
    assign stat.div_last = (step_reg == KB'(epid_pkg::DIV_STEPS - 1));

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // Record state: shift the window, update totals, clear at record end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg     <= '0;
            middle_reg    <= '0;
            mid_time_reg  <= '0;
            seen_reg      <= '0;
            count_reg     <= '0;
            last_time_reg <= '0;
            sum_reg       <= '0;
        end
        else if (cmd.take)
        begin
            if (in_data.record_end)
            begin
                older_reg     <= '0;
                middle_reg    <= '0;
                mid_time_reg  <= '0;
                seen_reg      <= '0;
                count_reg     <= '0;
                last_time_reg <= '0;
                sum_reg       <= '0;
            end
            else
            begin
                older_reg    <= middle_reg;
                middle_reg   <= in_data.sample_value;
                mid_time_reg <= in_data.sample_time;
                if (seen_reg != 2'd2)
                begin
                    seen_reg <= seen_reg + 2'd1;
                end
                count_reg <= count_next;
                sum_reg   <= sum_next;
                if (is_peak)
                begin
                    last_time_reg <= mid_time_reg;
                end
            end
        end
    end

    // Divider: load on every accepted input, then step after a record end that needs a mean.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            quot_reg <= sum_next;
            rem_reg  <= '0;
            dvsr_reg <= count_next - CB'(1);
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg + KB'(1);
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish || cmd.div_finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            out_reg.peak_found    <= is_peak;
            out_reg.peak_time     <= is_peak ? mid_time_reg : '0;
            out_reg.peak_total    <= count_next;
            out_reg.mean_interval <= '0;
            out_reg.record_done   <= in_data.record_end;
        end
        else if (cmd.div_finish)
        begin
            out_reg.mean_interval <= mean_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/ecg_peak_interval_detector.sv @@
// Top level of the ECG peak interval detector.
`timescale 1ns / 1ps

// Usage:
// Samples of one record enter on in_data with in_valid; a transaction is taken at
// a clock edge where in_valid is high and in_stall is low. Each input yields one
// result on out_data, judging the sample before it as a possible peak; the result
// is taken at an edge where out_valid is high and out_stall is low.
// A result appears in the cycle after its input is taken. A record end with two
// or more peaks runs a restoring divider for the mean interval, one quotient bit
// per cycle: that result follows the last divider step, and in_stall stays
// high meanwhile. Other inputs are taken one per cycle while out_stall is low.
// While the receiver stalls, the result waits in the output register and
// in_stall rises, so no transaction is lost. The threshold is written with
// cfg_wr_en and cfg_wr_data while the block is idle.
// Reset clears the threshold, the record state and the output valid flag.
// After a record end the record state clears and the threshold is kept.

module ecg_peak_interval_detector (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic signed [epid_pkg::SAMPLE_BITS-1:0] cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  epid_pkg::epid_in_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output epid_pkg::epid_out_t                   out_data
);

    epid_pkg::epid_cmd_t  cmd;
    epid_pkg::epid_stat_t stat;

    // Sequencing of accepts and the divider.
    epid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Peak detection, accumulation and result storage.
    epid_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
